[design/idp_pkg.sv]
`default_nettype none
package idp_pkg;

	localparam int Columns = 8;
	localparam int ActW = 8;
	localparam int WeightW = 8;
	localparam int ProdW = ActW + WeightW;
	localparam int SumW = 32;
	localparam int QDepth = 2;
	localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW = $clog2(QDepth + 1);
	localparam int AddrW = 3;
	localparam int DataW = 32;

	localparam logic RegAccMode = 1'b0;

	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [SumW-1:0] sum_t;
	typedef logic signed [WeightW-1:0] weight_t;

	typedef struct packed {
		prod_t [Columns-1:0] prod;
		logic clear;
		logic last;
	} step_t;

	typedef sum_t [Columns-1:0] sum_vec_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage
`default_nettype wire

[design/idp_if.sv]
`default_nettype none
interface idp_in_if;
	logic valid;
	logic ready;
	logic signed [7:0] activation;
	logic signed [7:0] weight_0;
	logic signed [7:0] weight_1;
	logic signed [7:0] weight_2;
	logic signed [7:0] weight_3;
	logic signed [7:0] weight_4;
	logic signed [7:0] weight_5;
	logic signed [7:0] weight_6;
	logic signed [7:0] weight_7;
	logic first_of_run;
	logic last_of_run;

	modport source (output valid, activation, weight_0, weight_1, weight_2, weight_3,
		weight_4, weight_5, weight_6, weight_7, first_of_run, last_of_run, input ready);
	modport sink (input valid, activation, weight_0, weight_1, weight_2, weight_3,
		weight_4, weight_5, weight_6, weight_7, first_of_run, last_of_run, output ready);
endinterface

interface idp_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] sum_0;
	logic signed [31:0] sum_1;
	logic signed [31:0] sum_2;
	logic signed [31:0] sum_3;
	logic signed [31:0] sum_4;
	logic signed [31:0] sum_5;
	logic signed [31:0] sum_6;
	logic signed [31:0] sum_7;

	modport source (output valid, sum_0, sum_1, sum_2, sum_3, sum_4, sum_5, sum_6, sum_7,
		input ready);
	modport sink (input valid, sum_0, sum_1, sum_2, sum_3, sum_4, sum_5, sum_6, sum_7,
		output ready);
endinterface
`default_nettype wire

[design/idp_front.sv]
`default_nettype none
module idp_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic acc_mode,
	idp_in_if.sink din,
	output idp_pkg::step_t step,
	output logic step_valid,
	input wire logic step_ready
);
	import idp_pkg::*;

	weight_t [Columns-1:0] w;
	step_t step_s1;
	logic valid_s1;
	logic take;

	assign w = {din.weight_7, din.weight_6, din.weight_5, din.weight_4,
		din.weight_3, din.weight_2, din.weight_1, din.weight_0};

	assign din.ready = !valid_s1 || step_ready;
	assign take = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int c = 0; c < Columns; c++) begin
				step_s1.prod[c] <= din.activation * w[c];
			end
			// mode only matters on a first step
			step_s1.clear <= din.first_of_run && !acc_mode;
			step_s1.last <= din.last_of_run;
		end
	end

	assign step = step_s1;
	assign step_valid = valid_s1;

endmodule
`default_nettype wire

[design/idp_queue.sv]
`default_nettype none
module idp_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire idp_pkg::step_t push_data,
	input wire idp_pkg::hs_t push_hs,
	output logic push_ready,
	output idp_pkg::step_t pop_data,
	output logic pop_valid,
	input wire logic pop_ready
);
	import idp_pkg::*;

	step_t mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != QCntW'(QDepth);
	assign pop_valid = count_q != '0;
	assign push = push_hs.valid && push_hs.ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

[design/idp_back.sv]
`default_nettype none
module idp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire idp_pkg::step_t step,
	input wire logic step_valid,
	output logic step_ready,
	idp_out_if.source dout
);
	import idp_pkg::*;

	sum_vec_t acc_q;
	sum_vec_t sum_q;
	sum_vec_t acc_nxt;
	logic out_valid_q;
	logic pop;

	assign step_ready = !step.last || !out_valid_q || dout.ready;
	assign pop = step_valid && step_ready;

	always_comb begin
		for (int c = 0; c < Columns; c++) begin
			acc_nxt[c] = (step.clear ? '0 : acc_q[c])
				+ {{(SumW - ProdW){step.prod[c][ProdW-1]}}, step.prod[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= acc_nxt;
			end
			if (pop && step.last) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && step.last) begin
			sum_q <= acc_nxt;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.sum_0 = sum_q[0];
	assign dout.sum_1 = sum_q[1];
	assign dout.sum_2 = sum_q[2];
	assign dout.sum_3 = sum_q[3];
	assign dout.sum_4 = sum_q[4];
	assign dout.sum_5 = sum_q[5];
	assign dout.sum_6 = sum_q[6];
	assign dout.sum_7 = sum_q[7];

endmodule
`default_nettype wire

[design/int8_dot_product_1x8_accumulator.sv]
// channel | dir | handshake     | payload
// din     | in  | valid/ready   | activation, weight_0..weight_7, first_of_run, last_of_run
// dout    | out | valid/ready   | sum_0..sum_7
// apb     | in  | psel/penable  | paddr, pwdata, prdata (accumulate_mode at 0x0)
//
// One item per cycle sustained while dout does not stall; an accepted din item passes the
// product register, then the queue, then the output register before dout valid rises.
// arst_n clears the accumulators, queue and mode register.
// A 2-entry queue between front and back lets each side stall on its own;
// dout stalls back up into din only once the queue is full.
`default_nettype none
module int8_dot_product_1x8_accumulator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [idp_pkg::AddrW-1:0] paddr,
	input wire logic [idp_pkg::DataW-1:0] pwdata,
	output logic [idp_pkg::DataW-1:0] prdata,
	output logic pready,
	idp_in_if.sink din,
	idp_out_if.source dout
);
	import idp_pkg::*;

	logic acc_mode_q;
	logic reg_sel;
	step_t f_step;
	step_t q_step;
	logic f_valid;
	logic q_push_ready;
	logic q_valid;
	logic b_ready;
	hs_t push_hs;

	assign pready = 1'b1;
	assign reg_sel = paddr[AddrW-1] == RegAccMode;
	assign prdata = reg_sel ? {{(DataW - 1){1'b0}}, acc_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			acc_mode_q <= pwdata[0];
		end
	end

	assign push_hs = '{valid: f_valid, ready: q_push_ready};

	idp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.acc_mode(acc_mode_q),
		.din(din),
		.step(f_step),
		.step_valid(f_valid),
		.step_ready(q_push_ready)
	);

	idp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(f_step),
		.push_hs(push_hs),
		.push_ready(q_push_ready),
		.pop_data(q_step),
		.pop_valid(q_valid),
		.pop_ready(b_ready)
	);

	idp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.step(q_step),
		.step_valid(q_valid),
		.step_ready(b_ready),
		.dout(dout)
	);

endmodule
`default_nettype wire

[design/idp_checker.sv]
`default_nettype none
module idp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [idp_pkg::AddrW-1:0] paddr,
	input wire logic [idp_pkg::DataW-1:0] pwdata,
	input wire logic [idp_pkg::DataW-1:0] prdata,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [31:0] out_sum_0,
	input wire logic [31:0] out_sum_7
);
	import idp_pkg::*;

	a_reset_no_out: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sum_0) && $stable(out_sum_7))
		else $error("stalled result changed");

	a_mode_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[AddrW-1]
		##1 psel && !pwrite && !paddr[AddrW-1]
		|-> prdata == {{(DataW - 1){1'b0}}, $past(pwdata[0])})
		else $error("mode register readback mismatch");

	a_unmapped_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[AddrW-1] |-> prdata == '0)
		else $error("unmapped read not zero");

endmodule

bind int8_dot_product_1x8_accumulator idp_checker u_idp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata),
	.out_valid(dout.valid),
	.out_ready(dout.ready),
	.out_sum_0(dout.sum_0),
	.out_sum_7(dout.sum_7)
);
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import idp_pkg::*;

	localparam logic [AddrW-1:0] AddrAccMode = AddrW'(4 * RegAccMode);
	localparam logic [AddrW-1:0] AddrSpare = AddrW'(4);
	localparam int DrainCycles = 8;
	localparam int QuietLimit = 5000;
	localparam int MaxPrinted = 40;

	typedef struct packed {
		logic signed [ActW-1:0] act;
		weight_t [Columns-1:0] wt;
		logic first;
		logic last;
	} step_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic pready;

	idp_in_if in_ch ();
	idp_out_if out_ch ();

	int8_dot_product_1x8_accumulator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.din(in_ch),
		.dout(out_ch)
	);

	sum_vec_t column_acc;
	logic acc_mode;
	sum_vec_t expected_sums[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int col, sum_t got, sum_t want);
		if (errors < MaxPrinted)
			$display("mismatch: %s col %0d got %0d expected %0d", what, col, got, want);
		errors++;
	endtask

	task automatic predict_step(step_item_t s);
		if (s.first && !acc_mode)
			column_acc = '0;
		for (int c = 0; c < Columns; c++)
			column_acc[c] = column_acc[c] + sum_t'(s.act) * sum_t'(s.wt[c]);
		if (s.last)
			expected_sums.push_back(column_acc);
	endtask

	task automatic drive_fields(step_item_t s);
		in_ch.activation = s.act;
		in_ch.weight_0 = s.wt[0];
		in_ch.weight_1 = s.wt[1];
		in_ch.weight_2 = s.wt[2];
		in_ch.weight_3 = s.wt[3];
		in_ch.weight_4 = s.wt[4];
		in_ch.weight_5 = s.wt[5];
		in_ch.weight_6 = s.wt[6];
		in_ch.weight_7 = s.wt[7];
		in_ch.first_of_run = s.first;
		in_ch.last_of_run = s.last;
	endtask

	task automatic send_step(step_item_t s);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		drive_fields(s);
		in_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_step(s);
	endtask

	// lower valid, wait out all results plus in-flight non-last items
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic apb_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (addr == AddrAccMode)
			acc_mode = data[0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [7:0] rand_byte();
		logic [7:0] corner[4] = '{8'h80, 8'h7f, 8'h00, 8'hff};
		if ($urandom_range(99) < 25)
			return corner[$urandom_range(3)];
		return 8'($urandom);
	endfunction

	function automatic step_item_t rand_step(logic first, logic last);
		step_item_t s;
		s.act = rand_byte();
		for (int c = 0; c < Columns; c++)
			s.wt[c] = rand_byte();
		s.first = first;
		s.last = last;
		return s;
	endfunction

	function automatic step_item_t mk(logic [7:0] act, logic [63:0] wv, logic first, logic last);
		step_item_t s;
		s.act = act;
		s.wt = wv;
		s.first = first;
		s.last = last;
		return s;
	endfunction

	task automatic send_runs(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 15) begin
				send_step(rand_step(1'($urandom_range(1)), 1'($urandom_range(1))));
				sent++;
			end else begin
				len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
				for (int i = 0; i < len; i++)
					send_step(rand_step(i == 0, i == len - 1));
				sent += len;
			end
		end
	endtask

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		// no first flag straight after reset
		send_step(mk(8'h7f, {8{8'h7f}}, 1'b0, 1'b0));
		send_step(mk(8'h80, 64'h807f00ff807f0180, 1'b0, 1'b1));
		// single-step runs at the extremes
		send_step(mk(8'h80, {8{8'h80}}, 1'b1, 1'b1));
		send_step(mk(8'h7f, {8{8'h80}}, 1'b1, 1'b1));
		send_step(mk(8'h7f, {8{8'h7f}}, 1'b1, 1'b1));
		// sums kept after emission
		send_step(mk(8'hff, 64'h0102030405060708, 1'b0, 1'b0));
		send_step(mk(8'h00, 64'hffffffffffffffff, 1'b0, 1'b1));
		send_step(mk(8'h01, {8{8'h55}}, 1'b1, 1'b0));
		send_step(mk(8'hff, {8{8'haa}}, 1'b0, 1'b0));
		send_step(mk(8'h40, 64'h80ff7f0001fe8102, 1'b0, 1'b1));
		// mode only sampled on a first step
		send_step(mk(8'h03, 64'h1122334455667788, 1'b1, 1'b0));
		drain();
		apb_write(AddrAccMode, 32'h1);
		send_step(mk(8'hfd, 64'h8899aabbccddeeff, 1'b0, 1'b1));
		send_step(mk(8'h80, 64'h7f807f807f807f80, 1'b1, 1'b1));
		send_step(mk(8'h7f, 64'h7f7f7f7f80808080, 1'b1, 1'b0));
		drain();
		apb_write(AddrAccMode, 32'h0);
		send_step(mk(8'h80, 64'h0080ff7f01fe0280, 1'b0, 1'b1));
		send_step(mk(8'h11, 64'h1234567890abcdef, 1'b1, 1'b1));
		drain();
		// upper data bits and unused address are ignored
		apb_write(AddrAccMode, 32'h1);
		apb_write(AddrAccMode, 32'hffff_fffe);
		apb_write(AddrSpare, 32'hffff_ffff);
		send_step(mk(8'h22, 64'hfedcba9876543210, 1'b1, 1'b1));
		drain();
	endtask

	task automatic test_overflow();
		idle_pct = 0;
		stall_pct = 0;
		apb_write(AddrAccMode, 32'h0);
		for (int i = 0; i < 96; i++)
			send_step(mk(8'h80, 64'h7f807f807f807f80, i == 0, (i % 16) == 15));
		drain();
	endtask

	task automatic test_random();
		int idle_set[4] = '{0, 60, 0, 18};
		int stall_set[4] = '{0, 0, 60, 18};
		for (int ph = 0; ph < 4; ph++) begin
			for (int md = 0; md < 2; md++) begin
				drain();
				idle_pct = idle_set[ph];
				stall_pct = stall_set[ph];
				apb_write(AddrAccMode, md ? 32'hffff_ffff : 32'h0);
				send_runs(145);
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		apb_write(AddrAccMode, 32'h0);
		hold_cycles = 400;
		for (int i = 0; i < 60; i++)
			send_step(rand_step($urandom_range(2) == 0, $urandom_range(2) == 0));
		drain();
		apb_write(AddrAccMode, 32'h1);
		stall_pct = 40;
		hold_cycles = 250;
		send_runs(50);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		drive_fields('0);
		column_acc = '0;
		acc_mode = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();
		test_backpressure();
		test_overflow();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready = 1'b0;
				hold_cycles--;
			end else begin
				out_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : p_check
		sum_vec_t got;
		sum_vec_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.sum_7, out_ch.sum_6, out_ch.sum_5, out_ch.sum_4,
				out_ch.sum_3, out_ch.sum_2, out_ch.sum_1, out_ch.sum_0};
			if (expected_sums.size() == 0) begin
				report_mismatch("unexpected item", 0, got[0], '0);
			end else begin
				want = expected_sums.pop_front();
				for (int c = 0; c < Columns; c++)
					if (got[c] !== want[c])
						report_mismatch("sum", c, got[c], want[c]);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else if (in_ch.valid || expected_sums.size() != 0)
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
`default_nettype wire
